[hw/rtl/camera_distance_sorter_core_assert.svh]
// ----------------------------------------------------------------------------
// camera_distance_sorter_core_assert.svh
// Assertion macros used by the sorter checker.
// ----------------------------------------------------------------------------
`ifndef CAMERA_DISTANCE_SORTER_CORE_ASSERT_SVH
`define CAMERA_DISTANCE_SORTER_CORE_ASSERT_SVH

// same-cycle implication, gated off during reset
`define CDS_ASSERT_SAME(lbl, clock, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, gated off during reset
`define CDS_ASSERT_NEXT(lbl, clock, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cdsort_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdsort_pkg
// Types and constants of the camera distance sorter.
// ----------------------------------------------------------------------------
package cdsort_pkg;

	localparam int MAX_ENTITIES = 64;
	localparam int COORD_BITS   = 24;

	localparam int ID_W   = 16;
	localparam int POS_W  = 24;
	localparam int DIST_W = 50;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * COORD_BITS + 1;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

	typedef struct packed {
		logic [ID_W-1:0]         entity_id;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic                    last_entity;
	} entity_t;

	typedef struct packed {
		logic [ID_W-1:0]   sorted_id;
		logic [DIST_W-1:0] distance_sq;
		logic              last_result;
		logic              overflowed;
	} result_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [POS_W-1:0] z;
	} camera_t;

	// finished key leaving the distance pipeline
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [ID_W-1:0]   id;
		logic [DIST_W-1:0] key;
	} key_item_t;

	// one chain slot
	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] key;
		logic [ID_W-1:0]   id;
	} slot_t;

	// broadcast to every cell
	typedef struct packed {
		logic              insert;
		logic              emit;
		logic [DIST_W-1:0] key;
		logic [ID_W-1:0]   id;
	} cell_ctl_t;

	localparam slot_t EMPTY_SLOT = '{valid: 1'b0, key: '0, id: '0};

endpackage
`default_nettype wire

[hw/rtl/cdsort_key.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdsort_key
// Three-stage squared-distance pipeline: differences, squares, sum.
// ----------------------------------------------------------------------------
module cdsort_key (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire cdsort_pkg::entity_t  entity,
	input  wire cdsort_pkg::camera_t  camera,
	output cdsort_pkg::key_item_t     key_item
);
	import cdsort_pkg::*;

	logic                     valid_s1, valid_s2, valid_s3;
	logic                     last_s1, last_s2, last_s3;
	logic [ID_W-1:0]          id_s1, id_s2, id_s3;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic [DIST_W-1:0]        key_s3;

	logic signed [DIFF_W-1:0]   px, py, pz, cx, cy, cz;
	logic signed [2*DIFF_W-1:0] prod_x, prod_y, prod_z;
	logic [SQ_W+1:0]            sum;

	// only the low COORD_BITS bits count, sign-extended
	assign px = {entity.pos_x[COORD_BITS-1], entity.pos_x[COORD_BITS-1:0]};
	assign py = {entity.pos_y[COORD_BITS-1], entity.pos_y[COORD_BITS-1:0]};
	assign pz = {entity.pos_z[COORD_BITS-1], entity.pos_z[COORD_BITS-1:0]};
	assign cx = {camera.x[COORD_BITS-1], camera.x[COORD_BITS-1:0]};
	assign cy = {camera.y[COORD_BITS-1], camera.y[COORD_BITS-1:0]};
	assign cz = {camera.z[COORD_BITS-1], camera.z[COORD_BITS-1:0]};

	assign prod_x = dx_s1 * dx_s1;
	assign prod_y = dy_s1 * dy_s1;
	assign prod_z = dz_s1 * dz_s1;

	assign sum = {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= px - cx;
		dy_s1   <= py - cy;
		dz_s1   <= pz - cz;
		id_s1   <= entity.entity_id;
		last_s1 <= entity.last_entity;

		sqx_s2  <= prod_x[SQ_W-1:0];
		sqy_s2  <= prod_y[SQ_W-1:0];
		sqz_s2  <= prod_z[SQ_W-1:0];
		id_s2   <= id_s1;
		last_s2 <= last_s1;

		key_s3  <= DIST_W'(sum);
		id_s3   <= id_s2;
		last_s3 <= last_s2;
	end

	assign key_item = '{valid: valid_s3, last: last_s3, id: id_s3, key: key_s3};

endmodule
`default_nettype wire

[hw/rtl/cdsort_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdsort_cell
// One slot of the insertion chain. Loads shift toward the tail, emission
// shifts toward the head.
// ----------------------------------------------------------------------------
module cdsort_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cdsort_pkg::cell_ctl_t ctl,
	input  wire cdsort_pkg::slot_t     left_slot,
	input  wire logic                  left_gt,
	input  wire logic                  left_ok,
	input  wire cdsort_pkg::slot_t     right_slot,
	output cdsort_pkg::slot_t          slot,
	output logic                       gt
);
	import cdsort_pkg::*;

	logic              valid_q;
	logic [DIST_W-1:0] key_q;
	logic [ID_W-1:0]   id_q;
	logic              take_left, take_new;

	// strictly greater: equal keys stay ahead, so ties keep load order
	assign gt        = valid_q && (key_q > ctl.key);
	assign take_left = ctl.insert && left_gt;
	assign take_new  = ctl.insert && !left_gt && left_ok && (gt || !valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.emit) begin
			valid_q <= right_slot.valid;
		end else if (take_left || take_new) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			key_q <= right_slot.key;
			id_q  <= right_slot.id;
		end else if (take_left) begin
			key_q <= left_slot.key;
			id_q  <= left_slot.id;
		end else if (take_new) begin
			key_q <= ctl.key;
			id_q  <= ctl.id;
		end
	end

	assign slot = '{valid: valid_q, key: key_q, id: id_q};

endmodule
`default_nettype wire

[hw/rtl/camera_distance_sorter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// camera_distance_sorter_core
// Sorts entity ids by squared distance to a camera position.
// ----------------------------------------------------------------------------
// Records are taken one per cycle while busy is low. Each key goes through a
// three-stage distance pipeline into a chain of MAX_ENTITIES cells that keeps
// the records sorted as they arrive (equal keys in load order). Once a record
// with last_entity is taken, busy rises; once its key has left the distance
// pipeline, the chain drains from its head, one result per cycle with
// result_valid high, until every stored record is out. Results cannot be
// stalled: each one is on the result port for exactly one cycle. busy falls
// after the final result. Records that find the chain full are dropped and
// overflowed is set on the final result.
// Camera registers are written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module camera_distance_sorter_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire cdsort_pkg::entity_t              entity,
	output logic                                  result_valid,
	output cdsort_pkg::result_t                   result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [cdsort_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cdsort_pkg::POS_W-1:0]     cfg_data
);
	import cdsort_pkg::*;

	camera_t   camera_q;
	logic      busy_q;
	logic      emit_q;
	logic      drop_q;
	logic      accept;
	logic      full;
	logic      final_out;
	key_item_t key_item;
	cell_ctl_t ctl;
	slot_t     slots [MAX_ENTITIES];
	logic      gts   [MAX_ENTITIES];

	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CAMERA_X: camera_q.x <= cfg_data;
				REG_CAMERA_Y: camera_q.y <= cfg_data;
				REG_CAMERA_Z: camera_q.z <= cfg_data;
				default:      ;
			endcase
		end
	end

	cdsort_key u_key (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.entity   (entity),
		.camera   (camera_q),
		.key_item (key_item)
	);

	assign full = slots[MAX_ENTITIES-1].valid;

	assign ctl = '{insert: key_item.valid && !full, emit: emit_q,
	               key: key_item.key, id: key_item.id};

	for (genvar i = 0; i < MAX_ENTITIES; i++) begin : g_cell
		slot_t left_slot, right_slot;
		logic  left_gt, left_ok;

		if (i == 0) begin : g_head
			assign left_slot = EMPTY_SLOT;
			assign left_gt   = 1'b0;
			assign left_ok   = 1'b1;
		end else begin : g_body
			assign left_slot = slots[i-1];
			assign left_gt   = gts[i-1];
			assign left_ok   = slots[i-1].valid;
		end

		if (i == MAX_ENTITIES - 1) begin : g_tail
			assign right_slot = EMPTY_SLOT;
		end else begin : g_inner
			assign right_slot = slots[i+1];
		end

		cdsort_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left_slot  (left_slot),
			.left_gt    (left_gt),
			.left_ok    (left_ok),
			.right_slot (right_slot),
			.slot       (slots[i]),
			.gt         (gts[i])
		);
	end

	// head cell is the one going out; run ends when the next cell is empty
	assign final_out = emit_q && !slots[1].valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			emit_q <= 1'b0;
			drop_q <= 1'b0;
		end else begin
			if (accept && entity.last_entity) begin
				busy_q <= 1'b1;
			end else if (final_out) begin
				busy_q <= 1'b0;
			end

			if (key_item.valid && key_item.last) begin
				emit_q <= 1'b1;
			end else if (final_out) begin
				emit_q <= 1'b0;
			end

			if (key_item.valid && full) begin
				drop_q <= 1'b1;
			end else if (final_out) begin
				drop_q <= 1'b0;
			end
		end
	end

	assign busy         = busy_q;
	assign result_valid = emit_q && slots[0].valid;
	assign result       = '{sorted_id: slots[0].id, distance_sq: slots[0].key,
	                        last_result: final_out, overflowed: final_out && drop_q};

endmodule
`default_nettype wire

[hw/rtl/cdsort_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdsort_checker
// Port-level checks on the sorter's run sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "camera_distance_sorter_core_assert.svh"

module cdsort_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire cdsort_pkg::entity_t entity,
	input wire logic                result_valid,
	input wire cdsort_pkg::result_t result
);
	import cdsort_pkg::*;

	`CDS_ASSERT_SAME(a_result_only_busy, clk, arst_n, result_valid, busy, "result outside a pass")
	`CDS_ASSERT_NEXT(a_last_sets_busy, clk, arst_n, start && !busy && entity.last_entity, busy, "last transfer did not raise busy")
	`CDS_ASSERT_NEXT(a_run_contiguous, clk, arst_n, result_valid && !result.last_result, result_valid, "gap inside a sorted run")
	`CDS_ASSERT_NEXT(a_final_frees, clk, arst_n, result_valid && result.last_result, !busy && !result_valid, "busy held after final result")
	`CDS_ASSERT_SAME(a_ovf_on_final, clk, arst_n, result_valid && !result.last_result, !result.overflowed, "overflow flag before final result")

endmodule

bind camera_distance_sorter_core cdsort_checker u_checker (.*);
`default_nettype wire
